// ----- rtl/cbm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int unsigned AddrW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned RomAddrW  = 21;
  localparam int unsigned RomBankW  = 7;
  localparam int unsigned RomOffW   = 14;
  localparam int unsigned RamOffW   = 13;
  localparam int unsigned RamBankW  = 2;
  localparam int unsigned ClkRegW   = 4;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned RamBytesPerBank = 8192;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_HAS_RAM   = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_HAS_TIMER = 8'd1;

  // write windows within 0x0000-0x7FFF, by address bits 14:13
  localparam logic [1:0] WIN_RAM_ENABLE = 2'b00;
  localparam logic [1:0] WIN_ROM_BANK   = 2'b01;
  localparam logic [1:0] WIN_RAM_BANK   = 2'b10;
  localparam logic [1:0] WIN_LATCH      = 2'b11;

  // external RAM window 0xA000-0xBFFF, by address bits 15:13
  localparam logic [2:0] RAM_WINDOW = 3'b101;

  localparam logic [3:0]       RAM_ENABLE_KEY = 4'hA;
  localparam logic [ByteW-1:0] ROM_BANK_MASK  = 8'h7F;
  localparam logic [ByteW-1:0] RAM_SEL_MAX    = 8'h03;
  localparam logic [ByteW-1:0] CLK_SEL_MIN    = 8'h08;
  localparam logic [ByteW-1:0] CLK_SEL_MAX    = 8'h0C;

  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_ROM   = 2'd1,
    SRC_RAM   = 2'd2,
    SRC_CLOCK = 2'd3
  } src_e;

  typedef enum logic [1:0] {
    CREQ_NONE  = 2'd0,
    CREQ_READ  = 2'd1,
    CREQ_WRITE = 2'd2,
    CREQ_LATCH = 2'd3
  } creq_e;

  // result fields that are known at decode time
  typedef struct packed {
    logic                ram_rd;
    src_e                src;
    logic [RomAddrW-1:0] rom_address;
    creq_e               creq;
    logic [ClkRegW-1:0]  creg;
    logic [ByteW-1:0]    cdata;
    logic                bad;
  } dec_t;

  // full result held in the output register
  typedef struct packed {
    logic [ByteW-1:0]    read_data;
    src_e                src;
    logic [RomAddrW-1:0] rom_address;
    creq_e               creq;
    logic [ClkRegW-1:0]  creg;
    logic [ByteW-1:0]    cdata;
    logic                bad;
  } rsp_t;

  typedef struct packed {
    logic read;
    logic write;
  } ram_cmd_t;

endpackage

// ----- rtl/cbm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_if
// Request, response and configuration channels of the bank mapper.
// ----------------------------------------------------------------------------
interface cbm_req_if import cbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [AddrW-1:0] bus_address;
  logic [ByteW-1:0] write_value;

  modport source(output valid, command, bus_address, write_value, input ready);
  modport sink(input valid, command, bus_address, write_value, output ready);
endinterface

interface cbm_rsp_if import cbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ByteW-1:0]    read_data;
  logic [1:0]          data_source;
  logic [RomAddrW-1:0] rom_address;
  logic [1:0]          clock_request;
  logic [ClkRegW-1:0]  clock_register;
  logic [ByteW-1:0]    clock_data;
  logic                bad_address;

  modport source(output valid, read_data, data_source, rom_address, clock_request,
                 clock_register, clock_data, bad_address, input ready);
  modport sink(input valid, read_data, data_source, rom_address, clock_request,
               clock_register, clock_data, bad_address, output ready);
endinterface

interface cbm_cfg_if import cbm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/cbm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_ram
// Single-port cartridge RAM, one read or write per cycle, registered read.
// ----------------------------------------------------------------------------
module cbm_ram import cbm_pkg::*; #(
  parameter int unsigned Depth = 32768,
  parameter int unsigned AW    = 15
) (
  input  logic             clk_i,
  input  ram_cmd_t         cmd_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [ByteW-1:0] wdata_i,
  output logic [ByteW-1:0] rdata_o
);

  logic [ByteW-1:0] mem [Depth];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem[addr_i] <= wdata_i;
    end
    if (cmd_i.read) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/cartridge_bank_mapper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// Bank controller: ROM address translation, banked cartridge RAM, clock requests.
// ----------------------------------------------------------------------------
// One bus request is accepted every cycle while the decode stage is free or
// advancing. Its result passes the decode stage, beside the registered RAM read,
// then the output register. Bank registers update at the accepting edge, so the
// next request already sees them. A decode stage and the output register form a
// two-deep buffer, so a new request is taken while a result waits. Cartridge RAM
// is not cleared; unwritten bytes read as arbitrary values. The user must write
// configuration through the cfg channel while the block is idle (not enforced).
module cartridge_bank_mapper import cbm_pkg::*; #(
  parameter int unsigned ROM_BANKS = 128,
  parameter int unsigned RAM_BANKS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbm_req_if.sink   req_i,
  cbm_rsp_if.source rsp_o,
  cbm_cfg_if.sink   cfg_i
);

  localparam int unsigned RamDepth = RAM_BANKS * RamBytesPerBank;
  localparam int unsigned RamAw    = $clog2(RamDepth);

  // bank remap tables, resolved at elaboration
  logic [RomBankW-1:0] rom_map_tbl [2**RomBankW];
  logic [RamBankW-1:0] ram_bank_tbl [2**RamBankW];

  for (genvar g = 0; g < 2**RomBankW; g++) begin : g_rom_tbl
    assign rom_map_tbl[g] = RomBankW'(g % ROM_BANKS);
  end
  for (genvar g = 0; g < 2**RamBankW; g++) begin : g_ram_tbl
    assign ram_bank_tbl[g] = RamBankW'(g % RAM_BANKS);
  end

  logic                has_ram_q, has_timer_q;
  logic                ram_en_q, ram_en_d;
  logic [RomBankW-1:0] rom_num_q, rom_num_d;
  logic [ByteW-1:0]    ram_sel_q, ram_sel_d;

  logic                in_fire, advance, ctrl;
  logic                s1_valid_q, out_valid_q;
  dec_t                dec, s1_q;
  rsp_t                out_q;
  ram_cmd_t            ram_cmd;
  logic [RamAw-1:0]    ram_addr;
  logic [ByteW-1:0]    ram_rdata;
  logic [ByteW-1:0]    rom_masked;

  assign ctrl       = has_ram_q | has_timer_q;
  assign in_fire    = req_i.valid & req_i.ready;
  assign advance    = s1_valid_q & (~out_valid_q | rsp_o.ready);
  assign req_i.ready = ~s1_valid_q | advance;
  assign cfg_i.ready = 1'b1;
  assign rom_masked = req_i.write_value & ROM_BANK_MASK;
  assign ram_addr   = RamAw'({ram_bank_tbl[ram_sel_q[RamBankW-1:0]],
                              req_i.bus_address[RamOffW-1:0]});

  // decode one request against the current bank state
  always_comb begin
    dec        = '0;
    dec.src    = SRC_NONE;
    dec.creq   = CREQ_NONE;
    ram_cmd    = '0;
    ram_en_d   = ram_en_q;
    rom_num_d  = rom_num_q;
    ram_sel_d  = ram_sel_q;
    if (!req_i.bus_address[AddrW-1]) begin
      if (!req_i.command) begin
        dec.src = SRC_ROM;
        if (req_i.bus_address[RomOffW]) begin
          dec.rom_address = {rom_map_tbl[rom_num_q], req_i.bus_address[RomOffW-1:0]};
        end else begin
          dec.rom_address = {{RomBankW{1'b0}}, req_i.bus_address[RomOffW-1:0]};
        end
      end else begin
        case (req_i.bus_address[RomOffW:RamOffW])
          WIN_RAM_ENABLE: begin
            if (ctrl) begin
              ram_en_d = (req_i.write_value[3:0] == RAM_ENABLE_KEY);
            end
          end
          WIN_ROM_BANK: begin
            rom_num_d = (rom_masked[RomBankW-1:0] == '0) ? RomBankW'(1)
                                                        : rom_masked[RomBankW-1:0];
          end
          WIN_RAM_BANK: begin
            if (ctrl) begin
              ram_sel_d = req_i.write_value;
            end
          end
          WIN_LATCH: begin
            if (has_timer_q) begin
              dec.src   = SRC_CLOCK;
              dec.creq  = CREQ_LATCH;
              dec.cdata = req_i.write_value;
            end
          end
          default: ;
        endcase
      end
    end else if (req_i.bus_address[AddrW-1:RamOffW] == RAM_WINDOW) begin
      if (ram_en_q) begin
        if (ram_sel_q <= RAM_SEL_MAX) begin
          if (has_ram_q) begin
            dec.src       = SRC_RAM;
            dec.ram_rd    = ~req_i.command;
            ram_cmd.read  = in_fire & ~req_i.command;
            ram_cmd.write = in_fire & req_i.command;
          end
        end else if (ram_sel_q >= CLK_SEL_MIN && ram_sel_q <= CLK_SEL_MAX) begin
          if (has_timer_q) begin
            dec.src  = SRC_CLOCK;
            dec.creg = ram_sel_q[ClkRegW-1:0];
            if (req_i.command) begin
              dec.creq  = CREQ_WRITE;
              dec.cdata = req_i.write_value;
            end else begin
              dec.creq = CREQ_READ;
            end
          end
        end
      end
    end else begin
      dec.bad = 1'b1;
    end
  end

  cbm_ram #(
    .Depth(RamDepth),
    .AW   (RamAw)
  ) u_ram (
    .clk_i  (clk_i),
    .cmd_i  (ram_cmd),
    .addr_i (ram_addr),
    .wdata_i(req_i.write_value),
    .rdata_o(ram_rdata)
  );

  // configuration and bank state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_ram_q   <= 1'b0;
      has_timer_q <= 1'b0;
      ram_en_q    <= 1'b0;
      rom_num_q   <= RomBankW'(1);
      ram_sel_q   <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.index == CFG_HAS_RAM) begin
        has_ram_q <= cfg_i.data[0];
      end
      if (cfg_i.valid && cfg_i.index == CFG_HAS_TIMER) begin
        has_timer_q <= cfg_i.data[0];
      end
      if (in_fire) begin
        ram_en_q  <= ram_en_d;
        rom_num_q <= rom_num_d;
        ram_sel_q <= ram_sel_d;
      end
    end
  end

  // decode stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= dec;
    end
    if (advance) begin
      out_q.read_data   <= s1_q.ram_rd ? ram_rdata : '0;
      out_q.src         <= s1_q.src;
      out_q.rom_address <= s1_q.rom_address;
      out_q.creq        <= s1_q.creq;
      out_q.creg        <= s1_q.creg;
      out_q.cdata       <= s1_q.cdata;
      out_q.bad         <= s1_q.bad;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.read_data      = out_q.read_data;
  assign rsp_o.data_source    = out_q.src;
  assign rsp_o.rom_address    = out_q.rom_address;
  assign rsp_o.clock_request  = out_q.creq;
  assign rsp_o.clock_register = out_q.creg;
  assign rsp_o.clock_data     = out_q.cdata;
  assign rsp_o.bad_address    = out_q.bad;

`ifndef SYNTHESIS
  a_rom_num_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rom_num_q != '0) else $error("rom bank register holds zero");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q) else $error("advanced request lost before output");

  a_bad_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.bad) |-> (out_q.src == SRC_NONE && out_q.creq == CREQ_NONE))
    else $error("unmapped request produced a source or clock request");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !rsp_o.ready) |-> !req_i.ready)
    else $error("request accepted with both stages full");
`endif

endmodule
